// ===== design/bdq_pkg.sv =====
package bdq_pkg;

    localparam int POOL_DEPTH_DEF   = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_APPEND     = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REWIND     = 3'd4,
        MODE_NEXT       = 3'd5,
        MODE_GET        = 3'd6,
        MODE_REMOVE     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADCUR = 2'd3
    } t_status;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // latch a new transaction
        logic rd;     // read cycle: node pool and free stack reads
        logic wr;     // write cycle: link updates, result capture
    } t_ctl;

endpackage

// ===== design/bdq_ctrl.sv =====
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        busy       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                busy     = 1'b1;
                o_ctl.rd = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                // next transaction may enter while this one retires
                o_ctl.wr = 1'b1;
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/bdq_datapath.sv =====
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int POOL_DEPTH   = POOL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CW          = $clog2(POOL_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [2:0]              i_mode,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_payload_out,
    output logic [CW-1:0]           o_count,
    output logic                    o_cursor_valid
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // latched transaction
    t_mode                   r_mode;
    logic [PAYLOAD_BITS-1:0] r_pay;

    // list state
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_cur,  n_cur;
    logic          r_cur_v, n_cur_v;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [CW-1:0] r_fresh, n_fresh;  // nodes never handed out start here
    logic [CW-1:0] r_fcnt,  n_fcnt;   // depth of the free stack

    // node pool; end-of-list links are never stored, head/tail compares stand in
    logic [PAYLOAD_BITS-1:0] m_pay  [POOL_DEPTH];
    logic [AW-1:0]           m_next [POOL_DEPTH];
    logic [AW-1:0]           m_prev [POOL_DEPTH];
    logic [AW-1:0]           m_free [POOL_DEPTH];

    logic [PAYLOAD_BITS-1:0] r_rd_pay;
    logic [AW-1:0]           r_rd_next, r_rd_prev, r_rd_free;

    logic [AW-1:0] rd_addr;
    logic [CW-1:0] fcnt_m1;

    logic                    we_pay, we_next, we_prev, we_free;
    logic [AW-1:0]           wa_pay, wa_next, wa_prev, wa_free;
    logic [AW-1:0]           wd_next, wd_prev, wd_free;
    logic [AW-1:0]           alloc;
    t_status                 status;
    logic [PAYLOAD_BITS-1:0] pout;

    logic [PAYLOAD_BITS-1:0] r_pout;
    t_status                 r_status;
    logic [CW-1:0]           r_count;
    logic                    r_cvalid;
    logic                    r_strobe;

    always_comb begin
        case (r_mode)
            MODE_POP_FRONT: rd_addr = r_head;
            MODE_POP_BACK:  rd_addr = r_tail;
            default:        rd_addr = r_cur;
        endcase
    end

    assign fcnt_m1 = r_fcnt - ONE_C;
    assign alloc   = (r_fresh < DEPTH_C) ? r_fresh[AW-1:0] : r_rd_free;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_cur   = r_cur;
        n_cur_v = r_cur_v;
        n_cnt   = r_cnt;
        n_fresh = r_fresh;
        n_fcnt  = r_fcnt;
        we_pay  = 1'b0;
        we_next = 1'b0;
        we_prev = 1'b0;
        we_free = 1'b0;
        wa_pay  = alloc;
        wa_next = alloc;
        wa_prev = alloc;
        wa_free = r_fcnt[AW-1:0];
        wd_next = r_head;
        wd_prev = r_tail;
        wd_free = rd_addr;
        status  = ST_DONE;
        pout    = '0;
        case (r_mode)
            MODE_PUSH_FRONT, MODE_APPEND: begin
                if (r_cnt == DEPTH_C) begin
                    status = ST_FULL;
                end else begin
                    we_pay = 1'b1;
                    if (r_fresh < DEPTH_C) begin
                        n_fresh = r_fresh + ONE_C;
                    end else begin
                        n_fcnt = fcnt_m1;
                    end
                    if (r_cnt == '0) begin
                        n_head = alloc;
                        n_tail = alloc;
                    end else if (r_mode == MODE_APPEND) begin
                        we_prev = 1'b1;          // prev[new] = tail
                        wd_prev = r_tail;
                        we_next = 1'b1;          // next[tail] = new
                        wa_next = r_tail;
                        wd_next = alloc;
                        n_tail  = alloc;
                    end else begin
                        we_next = 1'b1;          // next[new] = head
                        wd_next = r_head;
                        we_prev = 1'b1;          // prev[head] = new
                        wa_prev = r_head;
                        wd_prev = alloc;
                        n_head  = alloc;
                    end
                    n_cnt = r_cnt + ONE_C;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (r_cnt == '0) begin
                    status = ST_EMPTY;
                end else begin
                    pout = r_rd_pay;
                    if (r_cur_v && r_cur == rd_addr) begin
                        n_cur_v = 1'b0;
                    end
                    if (r_cnt != ONE_C) begin
                        if (r_mode == MODE_POP_FRONT) begin
                            n_head = r_rd_next;
                        end else begin
                            n_tail = r_rd_prev;
                        end
                    end
                    we_free = 1'b1;
                    n_fcnt  = r_fcnt + ONE_C;
                    n_cnt   = r_cnt - ONE_C;
                end
            end
            MODE_REWIND: begin
                n_cur_v = (r_cnt != '0);
                n_cur   = r_head;
            end
            MODE_NEXT: begin
                if (!r_cur_v) begin
                    status = ST_BADCUR;
                end else if (r_cur == r_tail) begin
                    n_cur_v = 1'b0;
                end else begin
                    n_cur = r_rd_next;
                end
            end
            MODE_GET: begin
                if (!r_cur_v) begin
                    status = ST_BADCUR;
                end else begin
                    pout = r_rd_pay;
                end
            end
            MODE_REMOVE: begin
                if (!r_cur_v) begin
                    status = ST_BADCUR;
                end else begin
                    pout = r_rd_pay;
                    if (r_cnt <= ONE_C) begin
                        n_cur_v = 1'b0;
                    end else if (r_cur == r_head) begin
                        n_cur  = r_rd_next;
                        n_head = r_rd_next;
                    end else if (r_cur == r_tail) begin
                        n_cur  = r_rd_prev;
                        n_tail = r_rd_prev;
                    end else begin
                        we_next = 1'b1;          // next[p] = x
                        wa_next = r_rd_prev;
                        wd_next = r_rd_next;
                        we_prev = 1'b1;          // prev[x] = p
                        wa_prev = r_rd_next;
                        wd_prev = r_rd_prev;
                        n_cur   = r_rd_next;
                    end
                    we_free = 1'b1;
                    n_fcnt  = r_fcnt + ONE_C;
                    n_cnt   = r_cnt - ONE_C;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // memories: reads in the read cycle, writes in the write cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_pay  <= m_pay[rd_addr];
            r_rd_next <= m_next[rd_addr];
            r_rd_prev <= m_prev[rd_addr];
            r_rd_free <= m_free[fcnt_m1[AW-1:0]];
        end
        if (i_ctl.wr) begin
            if (we_pay) begin
                m_pay[wa_pay] <= r_pay;
            end
            if (we_next) begin
                m_next[wa_next] <= wd_next;
            end
            if (we_prev) begin
                m_prev[wa_prev] <= wd_prev;
            end
            if (we_free) begin
                m_free[wa_free] <= wd_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mode <= t_mode'(i_mode);
            r_pay  <= i_payload_in;
        end
        if (i_ctl.wr) begin
            r_status <= status;
            r_pout   <= pout;
            r_count  <= n_cnt;
            r_cvalid <= n_cur_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cur    <= '0;
            r_cur_v  <= 1'b0;
            r_cnt    <= '0;
            r_fresh  <= '0;
            r_fcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.wr;
            if (i_ctl.wr) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_cur   <= n_cur;
                r_cur_v <= n_cur_v;
                r_cnt   <= n_cnt;
                r_fresh <= n_fresh;
                r_fcnt  <= n_fcnt;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_payload_out  = r_pout;
    assign o_count        = r_count;
    assign o_cursor_valid = r_cvalid;

endmodule

// ===== design/bounded_deque_with_cursor_unit.sv =====
// Bounded deque with one cursor, kept as a doubly linked list in a pool of
// POOL_DEPTH nodes. Issue a transaction by raising start while busy is low;
// i_mode picks push front, append back, pop front, pop back, rewind, next,
// get or remove-at-cursor. Exactly one result comes back per transaction,
// shown for a single cycle with o_strobe high; the receiver cannot stall it,
// so it must capture the result in that cycle. Each transaction has a read
// state, reading the node pool (payload, next and prev links, and the free
// stack) at the node in play, then a write state, writing the new links
// and latching the result. The write state also accepts the next one, so
// with start held high they run back to back; a result appears in the cycle
// after its write state. Errors are reported in o_status
// (list empty, pool full, cursor invalid) and leave the state unchanged;
// o_payload_out is zero unless a value was popped, read or removed.
// o_count gives the element count after the transaction and o_cursor_valid
// whether the cursor points at an element. Nodes come first from a counter of
// never-used nodes, then from a stack of released ones, so no clearing pass
// is needed after reset.
module bounded_deque_with_cursor_unit
    import bdq_pkg::*;
#(
    parameter int POOL_DEPTH   = POOL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CW          = $clog2(POOL_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_mode,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_payload_out,
    output logic [CW-1:0]           o_count,
    output logic                    o_cursor_valid
);

    t_ctl ctl;

    // sequencer: idle / read / write
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    // node pool, free stack, list registers and result registers
    bdq_datapath #(
        .POOL_DEPTH   (POOL_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_mode         (i_mode),
        .i_payload_in   (i_payload_in),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_payload_out  (o_payload_out),
        .o_count        (o_count),
        .o_cursor_valid (o_cursor_valid)
    );

endmodule

// ===== tb/bdq_result_checker.sv =====
// Watches both channels of the deque, keeps a shadow deque of its own and
// checks every strobed result against the oldest predicted one.
module bdq_result_checker
    import bdq_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [2:0]                  i_mode,
    input  logic [PAYLOAD_BITS_DEF-1:0] i_payload_in,
    input  logic                        i_strobe,
    input  logic [1:0]                  i_status,
    input  logic [PAYLOAD_BITS_DEF-1:0] i_payload_out,
    input  logic [4:0]                  i_count,
    input  logic                        i_cursor_valid,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_full_hits,
    output int                          o_empty_hits,
    output int                          o_badcur_hits
);

    localparam int POOL = POOL_DEPTH_DEF;
    localparam int PW   = PAYLOAD_BITS_DEF;
    localparam int IW   = $clog2(POOL + 1);
    localparam logic [IW-1:0] NIL = IW'(POOL);

    typedef struct packed {
        t_status         status;
        logic [PW-1:0]   payload;
        logic [IW-1:0]   count;
        logic            cursor_valid;
    } t_deque_result;

    // shadow deque
    logic [PW-1:0]   node_val  [POOL];
    logic [IW-1:0]   node_nxt  [POOL];
    logic [IW-1:0]   node_prv  [POOL];
    logic [POOL-1:0] node_free;
    logic [IW-1:0]   head_idx, tail_idx, cursor_idx, elem_cnt;

    t_deque_result pending_results[$];
    int err_cnt, result_cnt, full_cnt, empty_cnt, badcur_cnt;

    task automatic apply_deque_op(input t_mode m, input logic [PW-1:0] word,
                                  output t_deque_result r);
        logic [IW-1:0] n, p, x;
        logic          cur_ok;
        int            i;
        r        = '0;
        r.status = ST_DONE;
        cur_ok   = (cursor_idx != NIL);
        case (m)
            MODE_PUSH_FRONT, MODE_APPEND: begin
                if (elem_cnt == IW'(POOL)) begin
                    r.status = ST_FULL;
                end else begin
                    n = NIL;
                    for (i = POOL - 1; i >= 0; i--)
                        if (node_free[i]) n = IW'(i);
                    node_free[n] = 1'b0;
                    node_val[n]  = word;
                    if (elem_cnt == 0) begin
                        node_nxt[n] = NIL;
                        node_prv[n] = NIL;
                        head_idx    = n;
                        tail_idx    = n;
                    end else if (m == MODE_APPEND) begin
                        node_nxt[n]        = NIL;
                        node_prv[n]        = tail_idx;
                        node_nxt[tail_idx] = n;
                        tail_idx           = n;
                    end else begin
                        node_prv[n]        = NIL;
                        node_nxt[n]        = head_idx;
                        node_prv[head_idx] = n;
                        head_idx           = n;
                    end
                    elem_cnt++;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (elem_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    n         = (m == MODE_POP_BACK) ? tail_idx : head_idx;
                    r.payload = node_val[n];
                    if (cursor_idx == n) cursor_idx = NIL;
                    if (elem_cnt == 1) begin
                        head_idx = NIL;
                        tail_idx = NIL;
                    end else if (m == MODE_POP_BACK) begin
                        tail_idx           = node_prv[n];
                        node_nxt[tail_idx] = NIL;
                    end else begin
                        head_idx           = node_nxt[n];
                        node_prv[head_idx] = NIL;
                    end
                    node_free[n] = 1'b1;
                    elem_cnt--;
                end
            end
            MODE_REWIND: begin
                cursor_idx = (elem_cnt != 0) ? head_idx : NIL;
            end
            MODE_NEXT: begin
                if (!cur_ok) r.status = ST_BADCUR;
                else         cursor_idx = node_nxt[cursor_idx];
            end
            MODE_GET: begin
                if (!cur_ok) r.status = ST_BADCUR;
                else         r.payload = node_val[cursor_idx];
            end
            default: begin
                if (!cur_ok) begin
                    r.status = ST_BADCUR;
                end else begin
                    n         = cursor_idx;
                    p         = node_prv[n];
                    x         = node_nxt[n];
                    r.payload = node_val[n];
                    if (elem_cnt == 1) begin
                        cursor_idx = NIL;
                        head_idx   = NIL;
                        tail_idx   = NIL;
                    end else if (p == NIL) begin
                        // removed the head: cursor moves forward
                        cursor_idx  = x;
                        head_idx    = x;
                        node_prv[x] = NIL;
                    end else if (x == NIL) begin
                        // removed the tail: cursor steps back
                        cursor_idx  = p;
                        tail_idx    = p;
                        node_nxt[p] = NIL;
                    end else begin
                        node_nxt[p] = x;
                        node_prv[x] = p;
                        cursor_idx  = x;
                    end
                    node_free[n] = 1'b1;
                    elem_cnt--;
                end
            end
        endcase
        r.count        = elem_cnt;
        r.cursor_valid = (cursor_idx != NIL);
    endtask

    always @(posedge i_clk) begin : watch
        t_deque_result want, got;
        if (!i_rst_n) begin
            node_free  = '1;
            head_idx   = NIL;
            tail_idx   = NIL;
            cursor_idx = NIL;
            elem_cnt   = '0;
            pending_results.delete();
            err_cnt    = 0;
            result_cnt = 0;
            full_cnt   = 0;
            empty_cnt  = 0;
            badcur_cnt = 0;
        end else begin
            // result side first: a strobe always belongs to an older transaction
            if (i_strobe) begin
                got.status       = t_status'(i_status);
                got.payload      = i_payload_out;
                got.count        = i_count;
                got.cursor_valid = i_cursor_valid;
                if (pending_results.size() == 0) begin
                    if (err_cnt < 10)
                        $display("MISCOMPARE: result with nothing outstanding, status %0d",
                                 i_status);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    result_cnt++;
                    case (want.status)
                        ST_FULL:   full_cnt++;
                        ST_EMPTY:  empty_cnt++;
                        ST_BADCUR: badcur_cnt++;
                        default:   ;
                    endcase
                    if (got.status !== want.status || got.payload !== want.payload ||
                        got.count !== want.count ||
                        got.cursor_valid !== want.cursor_valid) begin
                        if (err_cnt < 10) begin
                            $write("MISCOMPARE result %0d: status %0d/%0d payload %h/%h ",
                                   result_cnt, want.status, got.status, want.payload,
                                   got.payload);
                            $display("count %0d/%0d cursor_valid %0b/%0b (exp/act)",
                                     want.count, got.count,
                                     want.cursor_valid, got.cursor_valid);
                        end
                        err_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_deque_op(t_mode'(i_mode), i_payload_in, want);
                pending_results.push_back(want);
            end
        end
        o_errors      <= err_cnt;
        o_pending     <= pending_results.size();
        o_results     <= result_cnt;
        o_full_hits   <= full_cnt;
        o_empty_hits  <= empty_cnt;
        o_badcur_hits <= badcur_cnt;
    end

endmodule

// ===== tb/tb_bounded_deque_with_cursor_unit.sv =====
// Stimulus side of the deque bench. The checker beside the DUT does all the
// prediction; this module only drives transactions and calls the verdict.
module tb_bounded_deque_with_cursor_unit;
    import bdq_pkg::*;

    localparam int PW          = PAYLOAD_BITS_DEF;
    localparam int ITEMS       = 1950;
    localparam int LIMIT       = 400000;
    localparam int DRAIN_SLACK = 8;        // result registers are loaded in the write cycle

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [2:0]    i_mode;
    logic [PW-1:0] i_payload_in;
    logic          o_strobe;
    logic [1:0]    o_status;
    logic [PW-1:0] o_payload_out;
    logic [4:0]    o_count;
    logic          o_cursor_valid;

    int errors, pending, results, full_hits, empty_hits, badcur_hits;
    int sent;
    int sender_idle;   // percent of cycles the sender sits out
    int cycle_cnt;

    bounded_deque_with_cursor_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_payload_in   (i_payload_in),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_payload_out  (o_payload_out),
        .o_count        (o_count),
        .o_cursor_valid (o_cursor_valid)
    );

    bdq_result_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_payload_in   (i_payload_in),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_payload_out  (o_payload_out),
        .i_count        (o_count),
        .i_cursor_valid (o_cursor_valid),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_full_hits    (full_hits),
        .o_empty_hits   (empty_hits),
        .o_badcur_hits  (badcur_hits)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("bounded_deque_with_cursor_unit: mismatch");
            $finish;
        end
    end

    // Payload words lean on the all-zero and all-one corners now and then;
    // the rest are fully random so every bit sees both values.
    function automatic logic [PW-1:0] pick_word();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return PW'($urandom);
    endfunction

    // One transaction: optional idle cycles, then hold start until the DUT
    // takes it. busy is read right after the edge, i.e. its pre-edge value,
    // which is exactly what the DUT saw when it accepted.
    task automatic send(input t_mode m, input logic [PW-1:0] word);
        while ($urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= m;
        i_payload_in <= word;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // Sender holds off until the checker has nothing outstanding. The first
    // edge lets the last acceptance show up in the pending count.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Random traffic comes in short runs so the list actually gets deep,
    // fills the pool, empties out, and the cursor walks real chains.
    task automatic random_burst();
        int kind, len, k, sel;
        kind = $urandom_range(9);
        if (kind < 3) begin
            // fill run: often runs into the full pool
            len = $urandom_range(20, 4);
            for (k = 0; k < len; k++)
                send($urandom_range(1) ? MODE_APPEND : MODE_PUSH_FRONT, pick_word());
        end else if (kind < 5) begin
            // drain run: often pops past empty
            len = $urandom_range(18, 3);
            for (k = 0; k < len; k++)
                send($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, pick_word());
        end else if (kind < 8) begin
            // cursor walk from the head, with reads and removals along the way
            send(MODE_REWIND, pick_word());
            len = $urandom_range(16, 2);
            for (k = 0; k < len; k++) begin
                sel = $urandom_range(9);
                if (sel < 5)      send(MODE_NEXT, pick_word());
                else if (sel < 8) send(MODE_GET, pick_word());
                else              send(MODE_REMOVE, pick_word());
            end
        end else begin
            // noise: any op, any order
            len = $urandom_range(8, 1);
            for (k = 0; k < len; k++)
                send(t_mode'($urandom_range(7)), pick_word());
        end
    endtask

    initial begin
        int want_idle;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_PUSH_FRONT;
        i_payload_in <= '0;
        sent         = 0;
        sender_idle  = 31;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // errors on an empty list: empty pops, no cursor for next/get/remove
        send(MODE_POP_FRONT, '1);
        send(MODE_POP_BACK, '0);
        send(MODE_NEXT, '0);
        send(MODE_GET, '0);
        send(MODE_REMOVE, '0);
        send(MODE_REWIND, '0);           // rewind on empty leaves cursor invalid
        // build  aaaa.. / 0 / ffff.. / 5555..
        send(MODE_PUSH_FRONT, '0);
        send(MODE_APPEND, '1);
        send(MODE_PUSH_FRONT, {(PW/2){2'b10}});
        send(MODE_APPEND, {(PW/2){2'b01}});
        send(MODE_REWIND, '0);
        send(MODE_GET, '0);
        send(MODE_NEXT, '0);
        send(MODE_GET, '0);
        send(MODE_REMOVE, '0);           // middle removal, cursor moves on
        send(MODE_NEXT, '0);
        send(MODE_REMOVE, '0);           // tail removal, cursor steps back
        send(MODE_NEXT, '0);             // next past the end
        send(MODE_REWIND, '0);
        send(MODE_POP_FRONT, '0);        // pops the node under the cursor
        send(MODE_REWIND, '0);
        send(MODE_REMOVE, '0);           // last element goes, list empties
        drain_results();

        // --- random part, idle mix changes with progress ---
        while (sent < ITEMS) begin
            want_idle = (sent < ITEMS / 3) ? 31 : (sent < 2 * ITEMS / 3) ? 53 : 0;
            if (want_idle != sender_idle) begin
                drain_results();
                sender_idle = want_idle;
            end else if ($urandom_range(39) == 0) begin
                drain_results();
            end
            random_burst();
        end

        drain_results();
        repeat (DRAIN_SLACK) @(posedge i_clk);

        $display("%0d transactions over all eight modes, sender idle 31%%, 53%%, then 0%%",
                 sent);
        $display("%0d results checked: %0d pool full, %0d list empty, %0d cursor invalid",
                 results, full_hits, empty_hits, badcur_hits);
        if (errors == 0 && pending == 0) begin
            $display("bounded_deque_with_cursor_unit: match");
        end else begin
            $display("bounded_deque_with_cursor_unit: mismatch");
        end
        $finish;
    end

endmodule
